FILE: hdl/cepm_pkg.sv
// shared constants and types for the clock edge pacing monitor
package cepm_pkg;

    localparam int HzWidth      = 30;
    localparam int WordWidth    = 32;
    localparam int ProdWidth    = WordWidth + HzWidth;
    localparam int DivSteps     = ProdWidth / 2;
    localparam int StepCntWidth = $clog2(DivSteps);
    localparam int InDataWidth  = 40;
    localparam int OutDataWidth = 360;
    localparam int CfgIdxWidth  = 2;

    localparam logic [HzWidth-1:0]   BaselineReset = 30'd300000000;
    localparam logic [HzWidth-1:0]   TargetReset   = 30'd300000000;
    localparam logic [WordWidth-1:0] IdleGapReset  = 32'd30000;

    localparam logic [2:0] REQ_CLK_WR   = 3'd0;
    localparam logic [2:0] REQ_OTHER_WR = 3'd1;
    localparam logic [2:0] REQ_CLK_REG  = 3'd2;
    localparam logic [2:0] REQ_DATA_REG = 3'd3;
    localparam logic [2:0] REQ_REPORT   = 3'd4;

    localparam logic [CfgIdxWidth-1:0] CFG_BASELINE = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_TARGET   = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_IDLE_GAP = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

FILE: hdl/clock_edge_pacing_monitor.sv
// clock edge pacing monitor: edge delay scaling and pacing statistics
// sequence: an accepted word passes the multiply and finish states, and a paced edge
//   also runs 31 two-bit divide steps in between on the single restoring divider
// a new word is taken only in idle, after the last one left the finish state, which waits while the output is held
// reset: synchronous active-low aresetn clears all statistics and edge tracking
//   and loads the config registers with their defaults
module clock_edge_pacing_monitor (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [cepm_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [cepm_pkg::WordWidth-1:0]       cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // level, timestamp, counter_on
    input  logic [cepm_pkg::InDataWidth-1:0]     s_tdata,
    // req_type
    input  logic [2:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // drive_level, extra_delay, call_count, edge_count, delayed_count,
    // idle_reset_count, counter_off_count, delay_total, delay_peak,
    // interval_peak, clock_reg_count, data_reg_count
    output logic [cepm_pkg::OutDataWidth-1:0]    m_tdata
);

    localparam int HW = cepm_pkg::HzWidth;
    localparam int WW = cepm_pkg::WordWidth;
    localparam int PW = cepm_pkg::ProdWidth;
    localparam int CW = cepm_pkg::StepCntWidth;

    cepm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    logic [HW-1:0] baseline_reg, target_reg;
    logic [WW-1:0] gap_reg;

    logic [2:0]    req_reg;
    logic          lvl_reg;
    logic [WW-1:0] ts_reg;
    logic          con_reg;
    logic [WW-1:0] elapsed_reg;
    logic [HW-1:0] diff_reg;
    logic          paced_reg, paced_next;
    logic [PW-1:0] dividend_reg, dividend_next;
    logic [HW-1:0] rem_reg, rem_next;
    logic [WW-1:0] quot_reg, quot_next;

    logic [WW-1:0] last_time_reg, last_time_next;
    logic          last_level_reg, last_level_next;
    logic          have_edge_reg, have_edge_next;
    logic [WW-1:0] calls_reg, calls_next;
    logic [WW-1:0] edges_reg, edges_next;
    logic [WW-1:0] delayed_reg, delayed_next;
    logic [WW-1:0] idle_reg, idle_next;
    logic [WW-1:0] off_reg, off_next;
    logic [WW-1:0] sum_reg, sum_next;
    logic [WW-1:0] dmax_reg, dmax_next;
    logic [WW-1:0] imax_reg, imax_next;
    logic [WW-1:0] creg_reg, creg_next;
    logic [WW-1:0] dreg_reg, dreg_next;

    logic                              m_tvalid_reg, m_tvalid_next;
    logic [cepm_pkg::OutDataWidth-1:0] m_tdata_reg, m_tdata_next;

    logic          accept;
    logic          is_edge;
    logic          out_free;
    logic [HW:0]   r1, r1s, r2, r2s;
    logic          ge1, ge2;
    logic [WW-1:0] extra;
    logic          drive;
    logic [WW-1:0] rep_calls, rep_edges, rep_delayed, rep_idle, rep_off;
    logic [WW-1:0] rep_sum, rep_dmax, rep_imax, rep_creg, rep_dreg;

    assign s_tready = (state_reg == cepm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_edge  = have_edge_reg && (lvl_reg != last_level_reg);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // two restoring divide steps per cycle
    always_comb begin
        r1  = {rem_reg, dividend_reg[PW-1]};
        ge1 = (r1 >= {1'b0, baseline_reg});
        r1s = ge1 ? (r1 - {1'b0, baseline_reg}) : r1;
        r2  = {r1s[HW-1:0], dividend_reg[PW-2]};
        ge2 = (r2 >= {1'b0, baseline_reg});
        r2s = ge2 ? (r2 - {1'b0, baseline_reg}) : r2;
    end

    always_comb begin
        extra = paced_reg ? quot_reg : '0;
        drive = 1'b0;
        if (req_reg == cepm_pkg::REQ_CLK_WR || req_reg == cepm_pkg::REQ_OTHER_WR) begin
            drive = lvl_reg;
        end
        if (req_reg == cepm_pkg::REQ_REPORT) begin
            rep_calls   = calls_reg;
            rep_edges   = edges_reg;
            rep_delayed = delayed_reg;
            rep_idle    = idle_reg;
            rep_off     = off_reg;
            rep_sum     = sum_reg;
            rep_dmax    = dmax_reg;
            rep_imax    = imax_reg;
            rep_creg    = creg_reg;
            rep_dreg    = dreg_reg;
        end else begin
            rep_calls   = '0;
            rep_edges   = '0;
            rep_delayed = '0;
            rep_idle    = '0;
            rep_off     = '0;
            rep_sum     = '0;
            rep_dmax    = '0;
            rep_imax    = '0;
            rep_creg    = '0;
            rep_dreg    = '0;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        paced_next      = paced_reg;
        dividend_next   = dividend_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        last_time_next  = last_time_reg;
        last_level_next = last_level_reg;
        have_edge_next  = have_edge_reg;
        calls_next      = calls_reg;
        edges_next      = edges_reg;
        delayed_next    = delayed_reg;
        idle_next       = idle_reg;
        off_next        = off_reg;
        sum_next        = sum_reg;
        dmax_next       = dmax_reg;
        imax_next       = imax_reg;
        creg_next       = creg_reg;
        dreg_next       = dreg_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        case (state_reg)
            cepm_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = cepm_pkg::ST_MUL;
                end
            end
            cepm_pkg::ST_MUL: begin
                paced_next = (req_reg == cepm_pkg::REQ_CLK_WR) && is_edge && con_reg
                             && (elapsed_reg <= gap_reg) && (baseline_reg != '0)
                             && (target_reg > baseline_reg);
                dividend_next = PW'(elapsed_reg) * PW'(diff_reg);
                rem_next      = '0;
                quot_next     = '0;
                cnt_next      = '0;
                state_next    = paced_next ? cepm_pkg::ST_DIV : cepm_pkg::ST_FIN;
            end
            cepm_pkg::ST_DIV: begin
                rem_next      = r2s[HW-1:0];
                dividend_next = {dividend_reg[PW-3:0], 2'b00};
                quot_next     = {quot_reg[WW-3:0], ge1, ge2};
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(cepm_pkg::DivSteps - 1)) begin
                    state_next = cepm_pkg::ST_FIN;
                end
            end
            cepm_pkg::ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, rep_dreg, rep_creg, rep_imax, rep_dmax, rep_sum,
                                     rep_off, rep_idle, rep_delayed, rep_edges, rep_calls,
                                     extra, drive};
                    state_next    = cepm_pkg::ST_IDLE;
                    case (req_reg)
                        cepm_pkg::REQ_CLK_WR: begin
                            calls_next = calls_reg + 1'b1;
                            if (is_edge) begin
                                edges_next = edges_reg + 1'b1;
                                if (!con_reg) begin
                                    off_next = off_reg + 1'b1;
                                end else if (elapsed_reg <= gap_reg) begin
                                    if (elapsed_reg > imax_reg) begin
                                        imax_next = elapsed_reg;
                                    end
                                    if (extra != '0) begin
                                        delayed_next = delayed_reg + 1'b1;
                                        sum_next     = sum_reg + extra;
                                        if (extra > dmax_reg) begin
                                            dmax_next = extra;
                                        end
                                    end
                                end else begin
                                    idle_next = idle_reg + 1'b1;
                                end
                            end
                            last_level_next = lvl_reg;
                            have_edge_next  = 1'b1;
                            if (con_reg) begin
                                last_time_next = ts_reg + extra;
                            end
                        end
                        cepm_pkg::REQ_CLK_REG: begin
                            creg_next      = creg_reg + 1'b1;
                            have_edge_next = 1'b0;
                        end
                        cepm_pkg::REQ_DATA_REG: begin
                            dreg_next = dreg_reg + 1'b1;
                        end
                        cepm_pkg::REQ_REPORT: begin
                            calls_next   = '0;
                            edges_next   = '0;
                            delayed_next = '0;
                            idle_next    = '0;
                            off_next     = '0;
                            sum_next     = '0;
                            dmax_next    = '0;
                            imax_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = cepm_pkg::ST_IDLE;
            end
        endcase
    end

    // input word capture and datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg     <= s_tuser;
            lvl_reg     <= s_tdata[0];
            ts_reg      <= s_tdata[WW:1];
            con_reg     <= s_tdata[WW+1];
            elapsed_reg <= s_tdata[WW:1] - last_time_reg;
            diff_reg    <= target_reg - baseline_reg;
        end
        paced_reg    <= paced_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        m_tdata_reg  <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cepm_pkg::ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            baseline_reg   <= cepm_pkg::BaselineReset;
            target_reg     <= cepm_pkg::TargetReset;
            gap_reg        <= cepm_pkg::IdleGapReset;
            last_time_reg  <= '0;
            last_level_reg <= 1'b0;
            have_edge_reg  <= 1'b0;
            calls_reg      <= '0;
            edges_reg      <= '0;
            delayed_reg    <= '0;
            idle_reg       <= '0;
            off_reg        <= '0;
            sum_reg        <= '0;
            dmax_reg       <= '0;
            imax_reg       <= '0;
            creg_reg       <= '0;
            dreg_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            last_time_reg  <= last_time_next;
            last_level_reg <= last_level_next;
            have_edge_reg  <= have_edge_next;
            calls_reg      <= calls_next;
            edges_reg      <= edges_next;
            delayed_reg    <= delayed_next;
            idle_reg       <= idle_next;
            off_reg        <= off_next;
            sum_reg        <= sum_next;
            dmax_reg       <= dmax_next;
            imax_reg       <= imax_next;
            creg_reg       <= creg_next;
            dreg_reg       <= dreg_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    cepm_pkg::CFG_BASELINE: baseline_reg <= cfg_wr_data[HW-1:0];
                    cepm_pkg::CFG_TARGET:   target_reg   <= cfg_wr_data[HW-1:0];
                    cepm_pkg::CFG_IDLE_GAP: gap_reg      <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: bench/clock_edge_pacing_monitor_tb.sv
// self-checking testbench for the clock edge pacing monitor: stream stimulus and scoreboard
`timescale 1ns / 100ps

module clock_edge_pacing_monitor_tb;

    localparam logic [cepm_pkg::CfgIdxWidth-1:0] CFG_UNUSED = 2'd3;
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
    localparam int HzMax       = 1000000000;
    localparam int StallLimit  = 3000;
    localparam int TailCycles  = 40;
    localparam int PhaseWords  = 48;
    localparam int PhaseCount  = 8;

    // result fields, highest bits first so drive_level lands at bit 0
    typedef struct packed {
        logic [31:0] data_reg_count;
        logic [31:0] clock_reg_count;
        logic [31:0] interval_peak;
        logic [31:0] delay_peak;
        logic [31:0] delay_total;
        logic [31:0] counter_off_count;
        logic [31:0] idle_reset_count;
        logic [31:0] delayed_count;
        logic [31:0] edge_count;
        logic [31:0] call_count;
        logic [31:0] extra_delay;
        logic        drive_level;
    } pace_result_t;

    localparam int ResultBits = $bits(pace_result_t);

    class pacing_scoreboard;
        logic [cepm_pkg::HzWidth-1:0] baseline = cepm_pkg::BaselineReset;
        logic [cepm_pkg::HzWidth-1:0] target   = cepm_pkg::TargetReset;
        logic [31:0]                  idle_gap = cepm_pkg::IdleGapReset;

        logic [31:0] last_stamp;
        logic        last_lvl;
        logic        have_edge;
        logic [31:0] calls, edges, delayed, idles, cnt_off;
        logic [31:0] delay_sum, delay_max, interval_hi, clock_regs, data_regs;

        pace_result_t expected_q[$];
        int unsigned errors;
        int unsigned n_checked;
        int unsigned n_stretched;
        int unsigned n_idle;
        int unsigned n_reports;

        function void clear_stats();
            calls = '0;
            edges = '0;
            delayed = '0;
            idles = '0;
            cnt_off = '0;
            delay_sum = '0;
            delay_max = '0;
            interval_hi = '0;
        endfunction

        function void reset_state();
            last_stamp = '0;
            last_lvl = 1'b0;
            have_edge = 1'b0;
            clock_regs = '0;
            data_regs = '0;
            clear_stats();
        endfunction

        function void write_reg(logic [cepm_pkg::CfgIdxWidth-1:0] idx, logic [31:0] val);
            case (idx)
                cepm_pkg::CFG_BASELINE: baseline = val[cepm_pkg::HzWidth-1:0];
                cepm_pkg::CFG_TARGET:   target = val[cepm_pkg::HzWidth-1:0];
                cepm_pkg::CFG_IDLE_GAP: idle_gap = val;
                default: ;
            endcase
        endfunction

        function logic [31:0] hold_for(logic [31:0] elapsed);
            logic [63:0] prod;
            if (baseline == '0 || target <= baseline) return '0;
            prod = 64'(elapsed) * 64'(target - baseline);
            return 32'(prod / 64'(baseline));
        endfunction

        function void note_word(logic [2:0] req, logic lvl, logic [31:0] stamp, logic cnt_on);
            pace_result_t r;
            logic [31:0] elapsed;
            logic [31:0] extra;
            r = '0;
            extra = '0;
            case (req)
                cepm_pkg::REQ_CLK_WR: begin
                    calls++;
                    if (have_edge && lvl != last_lvl) begin
                        edges++;
                        if (!cnt_on) begin
                            cnt_off++;
                        end else begin
                            elapsed = stamp - last_stamp;
                            if (elapsed <= idle_gap) begin
                                extra = hold_for(elapsed);
                                if (elapsed > interval_hi) interval_hi = elapsed;
                                if (extra != '0) begin
                                    delayed++;
                                    delay_sum += extra;
                                    if (extra > delay_max) delay_max = extra;
                                    n_stretched++;
                                end
                            end else begin
                                idles++;
                                n_idle++;
                            end
                        end
                    end
                    last_lvl = lvl;
                    have_edge = 1'b1;
                    if (cnt_on) last_stamp = stamp + extra;
                    r.drive_level = lvl;
                    r.extra_delay = extra;
                end
                cepm_pkg::REQ_OTHER_WR: r.drive_level = lvl;
                cepm_pkg::REQ_CLK_REG: begin
                    clock_regs++;
                    have_edge = 1'b0;
                end
                cepm_pkg::REQ_DATA_REG: data_regs++;
                cepm_pkg::REQ_REPORT: begin
                    r.call_count = calls;
                    r.edge_count = edges;
                    r.delayed_count = delayed;
                    r.idle_reset_count = idles;
                    r.counter_off_count = cnt_off;
                    r.delay_total = delay_sum;
                    r.delay_peak = delay_max;
                    r.interval_peak = interval_hi;
                    r.clock_reg_count = clock_regs;
                    r.data_reg_count = data_regs;
                    clear_stats();
                    n_reports++;
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [cepm_pkg::OutDataWidth-1:0] data);
            pace_result_t want;
            pace_result_t got;
            if (expected_q.size() == 0) begin
                $error("result word with no expectation waiting: 0x%0h", data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            got = data[ResultBits-1:0];
            n_checked++;
            cmp_field("drive_level", 32'(want.drive_level), 32'(got.drive_level));
            cmp_field("extra_delay", want.extra_delay, got.extra_delay);
            cmp_field("call_count", want.call_count, got.call_count);
            cmp_field("edge_count", want.edge_count, got.edge_count);
            cmp_field("delayed_count", want.delayed_count, got.delayed_count);
            cmp_field("idle_reset_count", want.idle_reset_count, got.idle_reset_count);
            cmp_field("counter_off_count", want.counter_off_count, got.counter_off_count);
            cmp_field("delay_total", want.delay_total, got.delay_total);
            cmp_field("delay_peak", want.delay_peak, got.delay_peak);
            cmp_field("interval_peak", want.interval_peak, got.interval_peak);
            cmp_field("clock_reg_count", want.clock_reg_count, got.clock_reg_count);
            cmp_field("data_reg_count", want.data_reg_count, got.data_reg_count);
            cmp_field("padding", '0, 32'(data[cepm_pkg::OutDataWidth-1:ResultBits]));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [cepm_pkg::CfgIdxWidth-1:0]    cfg_index = '0;
    logic [cepm_pkg::WordWidth-1:0]      cfg_wr_data = '0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [cepm_pkg::InDataWidth-1:0]    s_tdata = '0;
    logic [2:0]                          s_tuser = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [cepm_pkg::OutDataWidth-1:0]   m_tdata;

    pacing_scoreboard sb;
    bit steady = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int unsigned words_sent = 0;

    clock_edge_pacing_monitor i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(99, 0);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [31:0] pick_interval();
        int mode;
        mode = $urandom_range(9, 0);
        if (mode < 4) return $urandom_range(255, 0);
        if (mode < 7) return $urandom_range(sb.idle_gap, 0);
        if (mode == 7) return sb.idle_gap;
        if (mode == 8) return sb.idle_gap + 32'd1;
        return $urandom();
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
                $display("no word moved for %0d cycles", StallLimit);
                $display("clock_edge_pacing_monitor verification failed");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [2:0] req, input logic lvl,
                             input logic [31:0] stamp, input logic cnt_on);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = cepm_pkg::InDataWidth'({cnt_on, stamp, lvl});
        s_tuser = req;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(req, lvl, stamp, cnt_on);
        words_sent++;
    endtask

    // clock pin write placed a given span after the last recorded stamp, which includes its extra delay
    task automatic clk_write(input logic lvl, input logic [31:0] span, input logic cnt_on);
        send_word(cepm_pkg::REQ_CLK_WR, lvl, sb.last_stamp + span, cnt_on);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [cepm_pkg::CfgIdxWidth-1:0] idx,
                             input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic configure_phase(input int ph);
        logic [31:0] base;
        logic [31:0] tgt;
        logic [31:0] gap;
        case (ph)
            0: begin
                base = '0;
                tgt = HzMax;
                gap = '1;
            end
            1: begin
                base = 32'd1;
                tgt = HzMax;
                gap = 32'd100000;
            end
            2: begin
                base = HzMax;
                tgt = 32'd1;
                gap = '0;
            end
            3: begin
                // upper bits must be dropped by the block
                base = 32'hC000_0001;
                tgt = '1;
                gap = $urandom();
            end
            default: begin
                tgt = $urandom_range(HzMax, 1);
                if ($urandom_range(3, 0) == 0) base = $urandom_range(HzMax, 1);
                else base = $urandom_range(tgt, 1);
                gap = ($urandom_range(1, 0) != 0) ? $urandom_range(200000, 0) : $urandom();
            end
        endcase
        write_reg(cepm_pkg::CFG_BASELINE, base);
        write_reg(cepm_pkg::CFG_TARGET, tgt);
        write_reg(cepm_pkg::CFG_IDLE_GAP, gap);
        write_reg(CFG_UNUSED, $urandom());
    endtask

    task automatic random_word();
        int pick;
        logic lvl;
        logic cnt_on;
        pick = $urandom_range(99, 0);
        if (pick < 68) begin
            lvl = ($urandom_range(9, 0) < 8) ? ~sb.last_lvl : sb.last_lvl;
            cnt_on = ($urandom_range(15, 0) != 0);
            clk_write(lvl, pick_interval(), cnt_on);
        end else if (pick < 76) begin
            send_word(cepm_pkg::REQ_OTHER_WR, 1'($urandom_range(1, 0)), $urandom(),
                      1'($urandom_range(1, 0)));
        end else if (pick < 80) begin
            send_word(cepm_pkg::REQ_CLK_REG, 1'($urandom_range(1, 0)), $urandom(),
                      1'($urandom_range(1, 0)));
        end else if (pick < 84) begin
            send_word(cepm_pkg::REQ_DATA_REG, 1'($urandom_range(1, 0)), $urandom(),
                      1'($urandom_range(1, 0)));
        end else if (pick < 91) begin
            send_word(cepm_pkg::REQ_REPORT, 1'($urandom_range(1, 0)), $urandom(),
                      1'($urandom_range(1, 0)));
        end else if (pick < 94) begin
            send_word(3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST)),
                      1'($urandom_range(1, 0)), $urandom(), 1'($urandom_range(1, 0)));
        end else begin
            send_word(3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)), $urandom(),
                      1'($urandom_range(1, 0)));
        end
    endtask

    initial begin
        sb = new;
        sb.reset_state();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // defaults: no stretch, edge tracking corner cases
        send_word(cepm_pkg::REQ_REPORT, 1'b0, '0, 1'b0);
        send_word(cepm_pkg::REQ_CLK_WR, 1'b0, '0, 1'b1);
        clk_write(1'b1, 32'd100, 1'b1);
        send_word(cepm_pkg::REQ_OTHER_WR, 1'b1, '1, 1'b1);
        send_word(cepm_pkg::REQ_OTHER_WR, 1'b0, '0, 1'b0);
        send_word(cepm_pkg::REQ_DATA_REG, 1'b1, $urandom(), 1'b1);
        clk_write(1'b0, 32'd50, 1'b0);
        clk_write(1'b0, 32'd20, 1'b1);
        clk_write(1'b1, cepm_pkg::IdleGapReset, 1'b1);
        clk_write(1'b0, cepm_pkg::IdleGapReset + 32'd1, 1'b1);
        send_word(cepm_pkg::REQ_CLK_REG, 1'b0, '0, 1'b0);
        clk_write(1'b1, 32'd10, 1'b1);
        send_word(REQ_SPARE_FIRST, 1'b1, '1, 1'b1);
        send_word(REQ_SPARE_LAST, 1'b1, '1, 1'b1);
        send_word(cepm_pkg::REQ_REPORT, 1'b1, '1, 1'b1);

        // widest ratio, timestamp wrap, full interval range
        drain();
        write_reg(cepm_pkg::CFG_BASELINE, 32'd1);
        write_reg(cepm_pkg::CFG_TARGET, HzMax);
        write_reg(cepm_pkg::CFG_IDLE_GAP, '1);
        write_reg(CFG_UNUSED, $urandom());
        send_word(cepm_pkg::REQ_CLK_REG, 1'b1, '1, 1'b1);
        send_word(cepm_pkg::REQ_CLK_WR, 1'b0, 32'hFFFF_FFF0, 1'b1);
        clk_write(1'b1, 32'h20, 1'b1);
        clk_write(1'b0, '1, 1'b1);
        clk_write(1'b1, '0, 1'b1);
        send_word(cepm_pkg::REQ_REPORT, 1'b0, '0, 1'b0);

        for (int ph = 0; ph < PhaseCount; ph++) begin
            drain();
            configure_phase(ph);
            steady = (ph % 3 == 2);
            repeat (PhaseWords) random_word();
        end

        drain();
        repeat (TailCycles) @(posedge aclk);
        $display("sent %0d words, checked %0d results over %0d settings", words_sent,
                 sb.n_checked, PhaseCount + 2);
        $display("stretched edges %0d, idle resets %0d, reports %0d", sb.n_stretched,
                 sb.n_idle, sb.n_reports);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("clock_edge_pacing_monitor verification clean");
        end else begin
            $display("clock_edge_pacing_monitor verification failed");
        end
        $finish;
    end

endmodule
